// ===== sv/mains_zero_cross_loss_monitor_defines.svh =====
// Assertion macros for the mains zero-cross loss monitor.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef MAINS_ZERO_CROSS_LOSS_MONITOR_DEFINES_SVH
`define MAINS_ZERO_CROSS_LOSS_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MZCL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MZCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MZCL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MZCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/mzcl_pkg.sv =====
// Shared types and constants for the mains zero-cross loss monitor.
// No dependencies; imported by every module of the block.
package mzcl_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_EDGE = 2'd1,
        FUNC_ARM  = 2'd2,
        FUNC_COLD = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_MON  = 2'd0,
        MODE_LOSS = 2'd1,
        MODE_REC  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_LOSS_SILENCE = 3'd0,
        REG_GAP_MIN      = 3'd1,
        REG_GAP_MAX      = 3'd2,
        REG_REC_EDGES    = 3'd3,
        REG_LOCK_EDGES   = 3'd4,
        REG_BOOT_GRACE   = 3'd5,
        REG_HOLDOFF      = 3'd6
    } reg_idx_t;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    localparam logic [15:0] LOSS_SILENCE_RST = 16'd200;
    localparam logic [7:0]  GAP_MIN_RST      = 8'd2;
    localparam logic [7:0]  GAP_MAX_RST      = 8'd22;
    localparam logic [3:0]  REC_EDGES_RST    = 4'd5;
    localparam logic [3:0]  LOCK_EDGES_RST   = 4'd3;
    localparam logic [15:0] BOOT_GRACE_RST   = 16'd300;
    localparam logic [15:0] HOLDOFF_RST      = 16'd200;

    typedef struct packed {
        func_t func;
        logic  light_is_dark;
        logic  count_limit_reached;
    } mzcl_in_t;

    typedef struct packed {
        logic [1:0] detect_mode;
        logic       locked_flag;
        logic       mains_present;
        logic       in_grace;
        logic       blank_now;
        logic       gear_advance;
        logic       light_request;
    } mzcl_out_t;

    typedef struct packed {
        logic [15:0] loss_silence_ms;
        logic [7:0]  edge_gap_min;
        logic [7:0]  edge_gap_max;
        logic [3:0]  recovery_edges_needed;
        logic [3:0]  lock_edges_needed;
        logic [15:0] boot_grace_ms;
        logic [15:0] recovery_holdoff_ms;
    } mzcl_cfg_t;

endpackage

// ===== sv/mzcl_regs.sv =====
// APB-style configuration registers of the mains zero-cross loss monitor.
// Depends on mzcl_pkg for the register map and the configuration struct.
module mzcl_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mzcl_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [mzcl_pkg::DATA_BITS-1:0]      pwdata,
    output logic [mzcl_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready,
    output mzcl_pkg::mzcl_cfg_t                 cfg
);
    import mzcl_pkg::*;

    mzcl_cfg_t cfg_reg;
    logic      wr_en;
    reg_idx_t  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.loss_silence_ms       <= LOSS_SILENCE_RST;
            cfg_reg.edge_gap_min          <= GAP_MIN_RST;
            cfg_reg.edge_gap_max          <= GAP_MAX_RST;
            cfg_reg.recovery_edges_needed <= REC_EDGES_RST;
            cfg_reg.lock_edges_needed     <= LOCK_EDGES_RST;
            cfg_reg.boot_grace_ms         <= BOOT_GRACE_RST;
            cfg_reg.recovery_holdoff_ms   <= HOLDOFF_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_LOSS_SILENCE: cfg_reg.loss_silence_ms       <= pwdata[15:0];
                REG_GAP_MIN:      cfg_reg.edge_gap_min          <= pwdata[7:0];
                REG_GAP_MAX:      cfg_reg.edge_gap_max          <= pwdata[7:0];
                REG_REC_EDGES:    cfg_reg.recovery_edges_needed <= pwdata[3:0];
                REG_LOCK_EDGES:   cfg_reg.lock_edges_needed     <= pwdata[3:0];
                REG_BOOT_GRACE:   cfg_reg.boot_grace_ms         <= pwdata[15:0];
                REG_HOLDOFF:      cfg_reg.recovery_holdoff_ms   <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_LOSS_SILENCE: prdata = DATA_BITS'(cfg_reg.loss_silence_ms);
            REG_GAP_MIN:      prdata = DATA_BITS'(cfg_reg.edge_gap_min);
            REG_GAP_MAX:      prdata = DATA_BITS'(cfg_reg.edge_gap_max);
            REG_REC_EDGES:    prdata = DATA_BITS'(cfg_reg.recovery_edges_needed);
            REG_LOCK_EDGES:   prdata = DATA_BITS'(cfg_reg.lock_edges_needed);
            REG_BOOT_GRACE:   prdata = DATA_BITS'(cfg_reg.boot_grace_ms);
            REG_HOLDOFF:      prdata = DATA_BITS'(cfg_reg.recovery_holdoff_ms);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== sv/mzcl_core.sv =====
// Detection state registers and combinational update logic of the mains zero-cross loss monitor.
// Depends on mzcl_pkg and the assertion macros in the defines header.
`include "mains_zero_cross_loss_monitor_defines.svh"

module mzcl_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  mzcl_pkg::mzcl_in_t   item,
    input  mzcl_pkg::mzcl_cfg_t  cfg,
    output mzcl_pkg::mzcl_out_t  result
);
    import mzcl_pkg::*;

    logic [TIME_BITS-1:0] tick_time_reg, tick_time_next;
    logic [TIME_BITS-1:0] last_edge_time_reg, last_edge_time_next;
    logic [TIME_BITS-1:0] recovery_prev_time_reg, recovery_prev_time_next;
    logic [TIME_BITS-1:0] lock_prev_time_reg, lock_prev_time_next;
    logic [TIME_BITS-1:0] arm_time_reg, arm_time_next;
    logic [TIME_BITS-1:0] holdoff_until_reg, holdoff_until_next;
    mode_t                mode_reg, mode_next;
    logic [3:0]           recovery_count_reg, recovery_count_next;
    logic [3:0]           lock_count_reg, lock_count_next;
    logic                 edge_seen_reg, edge_seen_next;
    logic                 locked_reg, locked_next;
    logic                 armed_reg, armed_next;
    logic                 skip_next_gear_reg, skip_next_gear_next;
    logic                 faded_reg, faded_next;
    logic                 holdoff_active_reg, holdoff_active_next;

    logic [TIME_BITS-1:0] loss_t, grace_t, holdoff_t, gap_min_t, gap_max_t;
    logic                 blank, gear, light;

    assign loss_t    = TIME_BITS'(cfg.loss_silence_ms);
    assign grace_t   = TIME_BITS'(cfg.boot_grace_ms);
    assign holdoff_t = TIME_BITS'(cfg.recovery_holdoff_ms);
    assign gap_min_t = TIME_BITS'(cfg.edge_gap_min);
    assign gap_max_t = TIME_BITS'(cfg.edge_gap_max);

    always_comb
    begin
        logic [TIME_BITS-1:0] tick_inc;
        logic [TIME_BITS-1:0] dt;
        logic [3:0]           cnt_inc;
        logic                 grace_inc;
        logic                 grace_cur;
        logic                 off;

        tick_time_next          = tick_time_reg;
        last_edge_time_next     = last_edge_time_reg;
        recovery_prev_time_next = recovery_prev_time_reg;
        lock_prev_time_next     = lock_prev_time_reg;
        arm_time_next           = arm_time_reg;
        holdoff_until_next      = holdoff_until_reg;
        mode_next               = mode_reg;
        recovery_count_next     = recovery_count_reg;
        lock_count_next         = lock_count_reg;
        edge_seen_next          = edge_seen_reg;
        locked_next             = locked_reg;
        armed_next              = armed_reg;
        skip_next_gear_next     = skip_next_gear_reg;
        faded_next              = faded_reg;
        holdoff_active_next     = holdoff_active_reg;
        blank                   = 1'b0;
        gear                    = 1'b0;
        light                   = 1'b0;

        tick_inc  = tick_time_reg + 1'b1;
        grace_inc = !armed_reg || ((tick_inc - arm_time_reg) < grace_t);
        grace_cur = !armed_reg || ((tick_time_reg - arm_time_reg) < grace_t);
        dt        = '0;
        cnt_inc   = '0;
        off       = faded_reg || item.light_is_dark;

        case (item.func)
            FUNC_TICK:
            begin
                tick_time_next = tick_inc;
                if (holdoff_active_reg && (tick_inc == holdoff_until_reg))
                    holdoff_active_next = 1'b0;
                if (locked_reg && !grace_inc)
                    skip_next_gear_next = 1'b0;
                if (edge_seen_reg && ((tick_inc - last_edge_time_reg) >= loss_t)
                    && locked_reg && !grace_inc && !holdoff_active_next
                    && ((mode_reg == MODE_MON) || (mode_reg == MODE_REC)))
                begin
                    mode_next           = MODE_LOSS;
                    recovery_count_next = '0;
                    faded_next          = 1'b1;
                    blank               = 1'b1;
                end
            end
            FUNC_EDGE:
            begin
                edge_seen_next      = 1'b1;
                last_edge_time_next = tick_time_reg;
                case (mode_reg)
                    MODE_MON:
                    begin
                        if (locked_reg)
                        begin
                            if (skip_next_gear_reg && !grace_cur)
                                skip_next_gear_next = 1'b0;
                        end
                        else if (lock_count_reg == '0)
                        begin
                            lock_prev_time_next = tick_time_reg;
                            lock_count_next     = 4'd1;
                        end
                        else
                        begin
                            dt                  = tick_time_reg - lock_prev_time_reg;
                            lock_prev_time_next = tick_time_reg;
                            cnt_inc             = lock_count_reg + 4'd1;
                            if (dt < gap_min_t)
                                lock_count_next = lock_count_reg;
                            else if (dt > gap_max_t)
                                lock_count_next = 4'd1;
                            else
                            begin
                                lock_count_next = cnt_inc;
                                if (cnt_inc >= cfg.lock_edges_needed)
                                    locked_next = 1'b1;
                            end
                        end
                    end
                    MODE_LOSS:
                    begin
                        recovery_prev_time_next = tick_time_reg;
                        recovery_count_next     = 4'd1;
                        mode_next               = MODE_REC;
                    end
                    MODE_REC:
                    begin
                        dt      = tick_time_reg - recovery_prev_time_reg;
                        cnt_inc = recovery_count_reg + 4'd1;
                        if (dt >= gap_min_t)
                        begin
                            recovery_prev_time_next = tick_time_reg;
                            if (dt > gap_max_t)
                                recovery_count_next = 4'd1;
                            else if (cnt_inc >= cfg.recovery_edges_needed)
                            begin
                                mode_next           = MODE_MON;
                                recovery_count_next = '0;
                                if (skip_next_gear_reg)
                                    skip_next_gear_next = 1'b0;
                                if (!skip_next_gear_reg || off)
                                begin
                                    gear = 1'b1;
                                    if (!item.count_limit_reached)
                                    begin
                                        faded_next = 1'b0;
                                        light      = 1'b1;
                                        if (holdoff_t != '0)
                                        begin
                                            holdoff_until_next  = tick_time_reg + holdoff_t;
                                            holdoff_active_next = 1'b1;
                                        end
                                        else
                                            holdoff_active_next = 1'b0;
                                    end
                                end
                            end
                            else
                                recovery_count_next = cnt_inc;
                        end
                    end
                    default:
                    begin
                        mode_next           = MODE_MON;
                        recovery_count_next = '0;
                    end
                endcase
            end
            FUNC_ARM:
            begin
                mode_next               = MODE_MON;
                edge_seen_next          = 1'b0;
                last_edge_time_next     = '0;
                recovery_prev_time_next = '0;
                recovery_count_next     = '0;
                locked_next             = 1'b0;
                lock_count_next         = '0;
                lock_prev_time_next     = '0;
                faded_next              = 1'b0;
                holdoff_until_next      = '0;
                holdoff_active_next     = 1'b0;
                arm_time_next           = tick_time_reg;
                armed_next              = 1'b1;
            end
            default:
            begin
                faded_next          = 1'b0;
                armed_next          = 1'b0;
                skip_next_gear_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        result.detect_mode   = mode_next;
        result.locked_flag   = locked_next;
        result.mains_present = edge_seen_next
                               && ((tick_time_next - last_edge_time_next) < loss_t);
        result.in_grace      = !armed_next || ((tick_time_next - arm_time_next) < grace_t);
        result.blank_now     = blank;
        result.gear_advance  = gear;
        result.light_request = light;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_time_reg          <= '0;
            last_edge_time_reg     <= '0;
            recovery_prev_time_reg <= '0;
            lock_prev_time_reg     <= '0;
            arm_time_reg           <= '0;
            holdoff_until_reg      <= '0;
            mode_reg               <= MODE_MON;
            recovery_count_reg     <= '0;
            lock_count_reg         <= '0;
            edge_seen_reg          <= 1'b0;
            locked_reg             <= 1'b0;
            armed_reg              <= 1'b0;
            skip_next_gear_reg     <= 1'b0;
            faded_reg              <= 1'b0;
            holdoff_active_reg     <= 1'b0;
        end
        else if (step)
        begin
            tick_time_reg          <= tick_time_next;
            last_edge_time_reg     <= last_edge_time_next;
            recovery_prev_time_reg <= recovery_prev_time_next;
            lock_prev_time_reg     <= lock_prev_time_next;
            arm_time_reg           <= arm_time_next;
            holdoff_until_reg      <= holdoff_until_next;
            mode_reg               <= mode_next;
            recovery_count_reg     <= recovery_count_next;
            lock_count_reg         <= lock_count_next;
            edge_seen_reg          <= edge_seen_next;
            locked_reg             <= locked_next;
            armed_reg              <= armed_next;
            skip_next_gear_reg     <= skip_next_gear_next;
            faded_reg              <= faded_next;
            holdoff_active_reg     <= holdoff_active_next;
        end
    end

    `MZCL_ASSERT_NEXT(a_blank_enters_loss, clk, rst_n, step && result.blank_now, mode_reg == MODE_LOSS && faded_reg)
    `MZCL_ASSERT_NEXT(a_gear_ends_recovery, clk, rst_n, step && result.gear_advance, mode_reg == MODE_MON && recovery_count_reg == '0)
    `MZCL_ASSERT_IMPL(a_light_needs_gear, clk, rst_n, result.light_request, result.gear_advance)
    `MZCL_ASSERT_IMPL(a_unlock_only_on_arm, clk, rst_n, step && locked_reg && !locked_next, item.func == FUNC_ARM)
    `MZCL_ASSERT_IMPL(a_count_idle_outside_rec, clk, rst_n, mode_reg != MODE_REC, recovery_count_reg == '0)

endmodule

// ===== sv/mains_zero_cross_loss_monitor.sv =====
// Mains zero-cross loss monitor: one item per clock sustained while out_ready is
// held high. An accepted item passes through the input register, then the
// combinational detection update into the result register; the state registers
// update as each item advances, and the following item sees the updated state. The
// input register takes a new item while a result still waits only if it is
// empty. Configuration registers reset to a 200 ms loss silence, gaps of 2 to
// 22 ticks, 5 recovery and 3 lock edges, 300 ms boot grace and 200 ms relight
// holdoff; write them only while the block is idle. Depends on mzcl_pkg,
// mzcl_regs and mzcl_core.
module mains_zero_cross_loss_monitor #(
    parameter int TIME_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  mzcl_pkg::mzcl_in_t               in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output mzcl_pkg::mzcl_out_t              out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mzcl_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [mzcl_pkg::DATA_BITS-1:0]   pwdata,
    output logic [mzcl_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready
);
    import mzcl_pkg::*;

    logic       in_valid_reg;
    mzcl_in_t   in_item_reg;
    logic       out_valid_reg;
    mzcl_out_t  out_item_reg;
    mzcl_cfg_t  cfg;
    mzcl_out_t  result;
    logic       advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    mzcl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mzcl_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_item;
        if (advance)
            out_item_reg <= result;
    end

endmodule
